>>> sv/sctf_pkg.sv
// Shared types, constants and helpers for the sky column texel fade unit.
package sctf_pkg;

    localparam int TEX_DEPTH   = 1024;
    localparam int TEX_AW      = $clog2(TEX_DEPTH);
    localparam int FRAC_SHIFT  = 16;
    localparam int FADE_SHIFT  = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] BOTTOM_EDGE  = 32'h0200_0000;
    localparam logic [8:0]  ALPHA_ONE    = 9'd256;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        CFG_START_FRAC   = 3'd0,
        CFG_FRAC_STEP    = 3'd1,
        CFG_TEX_HEIGHT   = 3'd2,
        CFG_TOP_COLOR    = 3'd3,
        CFG_BOTTOM_COLOR = 3'd4
    } t_cfg_index;

    // One queued item: either a texel load or a draw with its resolved fraction.
    typedef struct packed {
        logic              is_draw;
        logic [31:0]       frac;
        logic [TEX_AW-1:0] addr;
        logic [23:0]       texel;
    } t_qentry;

    typedef struct packed {
        logic [10:0] height;
        logic [23:0] top;
        logic [23:0] bottom;
    } t_fade_cfg;

    // Arithmetic-shifted fraction clamped to 0..256.
    function automatic logic [8:0] clamp_alpha(input logic [17:0] v);
        logic [8:0] res;
        if (v[17]) begin
            res = 9'd0;
        end else if (v[16:0] > 17'(ALPHA_ONE)) begin
            res = ALPHA_ONE;
        end else begin
            res = v[8:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] tgt,
                                               input logic [8:0] a);
        logic [16:0] sum;
        sum = 17'(c * a) + 17'(tgt * (ALPHA_ONE - a));
        return sum[15:8];
    endfunction

endpackage

>>> sv/sky_column_texel_fade_unit.sv
// Sky column texel fade unit: top level with configuration registers.
// A draw item passes through a queue slot and the s1, s2, s3 and output registers before its result shows.
// Throughput: one item per cycle while the queue has room; a load item takes one queue slot and yields nothing.
// The rate is set by the fraction accumulator add and one texel store port per cycle.
// Reset (synchronous, active low) clears registers (height goes to 128), accumulator, queue and pipeline valids;
// the texel store is not cleared and holds garbage until written.
module sky_column_texel_fade_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic        i_first_pixel,
    input  logic [9:0]  i_texel_address,
    input  logic [7:0]  i_texel_red,
    input  logic [7:0]  i_texel_green,
    input  logic [7:0]  i_texel_blue,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sctf_pkg::*;

    logic [31:0] r_start_frac;
    logic [31:0] r_frac_step;
    logic [10:0] r_height;
    logic [23:0] r_top_color;
    logic [23:0] r_bottom_color;

    t_fade_cfg fade_cfg;
    t_qentry   push_entry;
    t_qentry   head_entry;
    logic      q_push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_frac   <= '0;
            r_frac_step    <= '0;
            r_height       <= 11'd128;
            r_top_color    <= '0;
            r_bottom_color <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_FRAC:   r_start_frac   <= i_cfg_data;
                CFG_FRAC_STEP:    r_frac_step    <= i_cfg_data;
                CFG_TEX_HEIGHT:   r_height       <= i_cfg_data[10:0];
                CFG_TOP_COLOR:    r_top_color    <= i_cfg_data[23:0];
                CFG_BOTTOM_COLOR: r_bottom_color <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign fade_cfg.height = r_height;
    assign fade_cfg.top    = r_top_color;
    assign fade_cfg.bottom = r_bottom_color;

    sctf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_first_pixel   (i_first_pixel),
        .i_texel_address (i_texel_address),
        .i_texel_red     (i_texel_red),
        .i_texel_green   (i_texel_green),
        .i_texel_blue    (i_texel_blue),
        .i_start_frac    (r_start_frac),
        .i_frac_step     (r_frac_step),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_entry       (push_entry)
    );

    sctf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    sctf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_q_pop     (q_pop),
        .i_cfg       (fade_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

endmodule

>>> sv/sctf_front.sv
// Front end: accepts items, resolves the draw fraction and queues the work.
module sctf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic               i_first_pixel,
    input  logic [9:0]         i_texel_address,
    input  logic [7:0]         i_texel_red,
    input  logic [7:0]         i_texel_green,
    input  logic [7:0]         i_texel_blue,
    input  logic [31:0]        i_start_frac,
    input  logic [31:0]        i_frac_step,
    input  logic               i_q_full,
    output logic               o_q_push,
    output sctf_pkg::t_qentry  o_q_entry
);
    import sctf_pkg::*;

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [31:0] frac;
    logic        accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign frac       = i_first_pixel ? i_start_frac : r_acc;
    assign n_acc      = frac + i_frac_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (accept && i_mode) begin
            r_acc <= n_acc;
        end
    end

    assign o_q_push          = accept;
    assign o_q_entry.is_draw = i_mode;
    assign o_q_entry.frac    = frac;
    assign o_q_entry.addr    = TEX_AW'(i_texel_address);
    assign o_q_entry.texel   = {i_texel_red, i_texel_green, i_texel_blue};

endmodule

>>> sv/sctf_queue.sv
// Short item queue between front end and back end.
module sctf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sctf_pkg::t_qentry  i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output sctf_pkg::t_qentry  o_entry
);
    import sctf_pkg::*;

    t_qentry           r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> sv/sctf_back.sv
// Back end: texel store, index multiply, store read and two fade stages.
module sctf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  sctf_pkg::t_qentry   i_q_entry,
    output logic                o_q_pop,
    input  sctf_pkg::t_fade_cfg i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_red,
    output logic [7:0]          o_out_green,
    output logic [7:0]          o_out_blue,
    output logic [7:0]          o_out_alpha
);
    import sctf_pkg::*;

    logic [23:0]       r_texel_mem [TEX_DEPTH];

    logic              r_s1_valid;
    logic [TEX_AW-1:0] r_s1_addr;
    logic [8:0]        r_s1_a_top;
    logic [8:0]        r_s1_a_bot;

    logic              r_s2_valid;
    logic [23:0]       r_s2_texel;
    logic [8:0]        r_s2_a_top;
    logic [8:0]        r_s2_a_bot;

    logic              r_s3_valid;
    logic [23:0]       r_s3_rgb;
    logic [8:0]        r_s3_a_bot;

    logic              r_out_valid;
    logic [23:0]       r_out_rgb;

    logic              en;
    logic signed [15:0] tex_t;
    logic signed [27:0] prod;
    logic [31:0]       bot_diff;
    logic [23:0]       n_s3_rgb;
    logic [23:0]       n_out_rgb;

    // Whole pipeline moves together; it freezes only while a result waits.
    assign en      = !r_out_valid || i_out_ready;
    assign o_q_pop = en && i_q_valid;

    // (frac << 8) >>> 16 is the signed middle slice of the fraction.
    assign tex_t    = i_q_entry.frac[FRAC_SHIFT+7:8];
    assign prod     = tex_t * $signed({1'b0, i_cfg.height});
    assign bot_diff = BOTTOM_EDGE - i_q_entry.frac;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_s3_rgb[ch*8 +: 8]  = mix_channel(r_s2_texel[ch*8 +: 8], i_cfg.top[ch*8 +: 8],
                                               r_s2_a_top);
            n_out_rgb[ch*8 +: 8] = mix_channel(r_s3_rgb[ch*8 +: 8], i_cfg.bottom[ch*8 +: 8],
                                               r_s3_a_bot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_q_valid && i_q_entry.is_draw;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_addr  <= prod[FRAC_SHIFT+TEX_AW-1:FRAC_SHIFT];
            r_s1_a_top <= clamp_alpha(i_q_entry.frac[31:FADE_SHIFT]);
            r_s1_a_bot <= clamp_alpha(bot_diff[31:FADE_SHIFT]);
            r_s2_a_top <= r_s1_a_top;
            r_s2_a_bot <= r_s1_a_bot;
            r_s3_rgb   <= n_s3_rgb;
            r_s3_a_bot <= r_s2_a_bot;
            r_out_rgb  <= n_out_rgb;
        end
    end

    // Texel store: loads write at pop, draws read one stage later, so order holds.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_q_valid && !i_q_entry.is_draw) begin
                r_texel_mem[i_q_entry.addr] <= i_q_entry.texel;
            end
            r_s2_texel <= r_texel_mem[r_s1_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_rgb[23:16];
    assign o_out_green = r_out_rgb[15:8];
    assign o_out_blue  = r_out_rgb[7:0];
    assign o_out_alpha = ALPHA_OPAQUE;

endmodule

>>> dv/sctf_pixel_check.sv
// Pixel checker for the sky column texel fade unit: predicts each drawn pixel and compares.
`timescale 1ns / 1ps

module sctf_pixel_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic        i_first_pixel,
    input  logic [9:0]  i_texel_address,
    input  logic [7:0]  i_texel_red,
    input  logic [7:0]  i_texel_green,
    input  logic [7:0]  i_texel_blue,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_red,
    input  logic [7:0]  i_out_green,
    input  logic [7:0]  i_out_blue,
    input  logic [7:0]  i_out_alpha,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import sctf_pkg::*;

    localparam int          MAX_REPORTS  = 10;
    localparam logic [10:0] RESET_HEIGHT = 11'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    t_pixel      expected_pixels[$];
    logic [23:0] column_texels[TEX_DEPTH];

    logic [31:0] start_frac_q;
    logic [31:0] step_q;
    logic [10:0] height_q;
    logic [23:0] top_q;
    logic [23:0] bottom_q;
    logic [31:0] frac_acc;

    int fail_count = 0;
    int checked    = 0;

    // Fade weight: fraction shifted down arithmetically, held to 0..256.
    function automatic logic [8:0] fade_weight(input logic [31:0] v);
        logic [31:0] w;
        logic [8:0]  res;
        w = $signed(v) >>> FADE_SHIFT;
        if (w[31]) begin
            res = '0;
        end else if (w > 32'(ALPHA_ONE)) begin
            res = ALPHA_ONE;
        end else begin
            res = w[8:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] tgt,
                                         input logic [8:0] a);
        logic [31:0] acc;
        acc = 32'(c) * 32'(a) + 32'(tgt) * 32'(ALPHA_ONE - a);
        return acc[15:8];
    endfunction

    function automatic t_pixel shade_pixel(input logic [31:0] frac);
        logic [31:0] row;
        logic [31:0] scaled;
        logic [31:0] index;
        logic [23:0] texel;
        logic [8:0]  a_top;
        logic [8:0]  a_bot;
        t_pixel      px;
        row    = $signed(frac << 8) >>> FRAC_SHIFT;
        scaled = row * {21'd0, height_q};
        index  = $signed(scaled) >>> FRAC_SHIFT;
        // out of range indices wrap onto the low address bits
        texel  = column_texels[index[TEX_AW-1:0]];
        a_top  = fade_weight(frac);
        a_bot  = fade_weight(BOTTOM_EDGE - frac);
        px.red   = blend(blend(texel[23:16], top_q[23:16], a_top), bottom_q[23:16], a_bot);
        px.green = blend(blend(texel[15:8], top_q[15:8], a_top), bottom_q[15:8], a_bot);
        px.blue  = blend(blend(texel[7:0], top_q[7:0], a_top), bottom_q[7:0], a_bot);
        px.alpha = ALPHA_OPAQUE;
        return px;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [31:0] frac;
        t_pixel      want;
        t_pixel      got;
        if (!i_rst_n) begin
            start_frac_q = '0;
            step_q       = '0;
            height_q     = RESET_HEIGHT;
            top_q        = '0;
            bottom_q     = '0;
            frac_acc     = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_FRAC:   start_frac_q = i_cfg_data;
                    CFG_FRAC_STEP:    step_q       = i_cfg_data;
                    CFG_TEX_HEIGHT:   height_q     = i_cfg_data[10:0];
                    CFG_TOP_COLOR:    top_q        = i_cfg_data[23:0];
                    CFG_BOTTOM_COLOR: bottom_q     = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode) begin
                    frac = i_first_pixel ? start_frac_q : frac_acc;
                    expected_pixels.push_back(shade_pixel(frac));
                    frac_acc = frac + step_q;
                end else begin
                    column_texels[i_texel_address[TEX_AW-1:0]] =
                        {i_texel_red, i_texel_green, i_texel_blue};
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_red, i_out_green, i_out_blue, i_out_alpha};
                if (expected_pixels.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: unexpected pixel r=%02h g=%02h b=%02h a=%02h", $realtime,
                                 got.red, got.green, got.blue, got.alpha);
                    end
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("%0t: pixel expected %02h%02h%02h%02h got %02h%02h%02h%02h",
                                     $realtime, want.red, want.green, want.blue, want.alpha,
                                     got.red, got.green, got.blue, got.alpha);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

>>> dv/sky_column_texel_fade_unit_test.sv
// Testbench top for the sky column texel fade unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module sky_column_texel_fade_unit_test;
    import sctf_pkg::*;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DRAW     = 1'b1;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 20;
    localparam int   PHASE_ITEMS   = 240;
    // Heights up to FILL_SLOTS keep every index in the lowest and highest FILL_SLOTS/2 slots.
    localparam int   FILL_SLOTS    = 256;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_mode;
    logic        i_first_pixel;
    logic [9:0]  i_texel_address;
    logic [7:0]  i_texel_red;
    logic [7:0]  i_texel_green;
    logic [7:0]  i_texel_blue;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int items_sent    = 0;
    int columns       = 0;
    int idle_cycles   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sky_column_texel_fade_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_first_pixel   (i_first_pixel),
        .i_texel_address (i_texel_address),
        .i_texel_red     (i_texel_red),
        .i_texel_green   (i_texel_green),
        .i_texel_blue    (i_texel_blue),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_out_alpha     (o_out_alpha),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    sctf_pixel_check u_pixel_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_first_pixel   (i_first_pixel),
        .i_texel_address (i_texel_address),
        .i_texel_red     (i_texel_red),
        .i_texel_green   (i_texel_green),
        .i_texel_blue    (i_texel_blue),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_red       (o_out_red),
        .i_out_green     (o_out_green),
        .i_out_blue      (o_out_blue),
        .i_out_alpha     (o_out_alpha),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we ||
            !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
                     idle_cycles, pending);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic mode, input logic first, input logic [9:0] addr,
                             input logic [23:0] rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_first_pixel   <= first;
        i_texel_address <= addr;
        i_texel_red     <= rgb[23:16];
        i_texel_green   <= rgb[15:8];
        i_texel_blue    <= rgb[7:0];
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic load_texel(input logic [9:0] addr, input logic [23:0] rgb);
        send_item(MODE_LOAD, 1'($urandom), addr, rgb);
    endtask

    task automatic draw_pixel(input logic first);
        send_item(MODE_DRAW, first, 10'($urandom), 24'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every pixel, then let trailing loads leave the pipeline.
    // It first lets the checker register the last accepted draw as pending.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_column(input logic [31:0] start, input logic [31:0] step,
                              input logic [10:0] height, input logic [23:0] top,
                              input logic [23:0] bottom);
        drain();
        write_reg(CFG_START_FRAC, start);
        write_reg(CFG_FRAC_STEP, step);
        write_reg(CFG_TEX_HEIGHT, {21'd0, height});
        write_reg(CFG_TOP_COLOR, {8'd0, top});
        write_reg(CFG_BOTTOM_COLOR, {8'd0, bottom});
        columns++;
    endtask

    task automatic random_column(input int n, inout int count);
        logic [31:0] start;
        logic [31:0] step;
        logic [10:0] height;
        int          r;
        case ($urandom_range(3))
            0: start = $urandom;
            1, 2: start = $urandom_range(32'h0240_0000) - 32'h0020_0000; // around the fade bands
            default: begin
                case ($urandom_range(3))
                    0: start = 32'h8000_0000;
                    1: start = 32'h7FFF_FFFF;
                    2: start = 32'h0000_0000;
                    default: start = BOTTOM_EDGE;
                endcase
            end
        endcase
        if ($urandom_range(3) == 0) begin
            step = $urandom;
        end else begin
            step = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        end
        case ($urandom_range(3))
            0, 1: height = 11'($urandom_range(1, FILL_SLOTS));
            2: height = 11'($urandom_range(FILL_SLOTS));
            default: begin
                case ($urandom_range(3))
                    0: height = 11'd0;
                    1: height = 11'd1;
                    2: height = 11'd2;
                    default: height = 11'(FILL_SLOTS);
                endcase
            end
        endcase
        set_column(start, step, height, 24'($urandom), 24'($urandom));
        draw_pixel(1'b1);
        for (int k = 1; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 20) begin
                load_texel(10'($urandom), 24'($urandom));
            end else if (r < 28) begin
                draw_pixel(1'b1);  // restart mid column
            end else begin
                draw_pixel(1'b0);
            end
        end
        count += n;
    endtask

    initial begin
        int phase_count;
        int slot;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_LOAD;
        i_first_pixel   = 1'b0;
        i_texel_address = '0;
        i_texel_red     = '0;
        i_texel_green   = '0;
        i_texel_blue    = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_START_FRAC;
        i_cfg_data      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 82;

        // Fill the bottom and top ends of the store, where every draw with a height up to FILL_SLOTS lands.
        for (int a = 0; a < FILL_SLOTS; a++) begin
            slot = (a < FILL_SLOTS / 2) ? a : TEX_DEPTH - FILL_SLOTS + a;
            if (a == 0) begin
                load_texel(10'(slot), 24'h00_0000);
            end else if (a == FILL_SLOTS - 1) begin
                load_texel(10'(slot), 24'hFF_FFFF);
            end else begin
                load_texel(10'(slot), 24'($urandom));
            end
        end

        // Reset settings: accumulator starts from zero without a first pixel.
        draw_pixel(1'b0);
        draw_pixel(1'b0);
        draw_pixel(1'b1);

        // Indices past the register list must change nothing.
        drain();
        for (int k = int'(CFG_BOTTOM_COLOR) + 1; k < (1 << $bits(i_cfg_index)); k++) begin
            write_reg(3'(k), 32'hFFFF_FFFF);
        end
        draw_pixel(1'b1);

        set_column(32'h7FFF_FFFF, 32'h8000_0000, 11'd2047, 24'hFF_FFFF, 24'h00_0000);
        draw_pixel(1'b1);
        draw_pixel(1'b0);
        draw_pixel(1'b0);

        set_column(32'h8000_0000, 32'h7FFF_FFFF, 11'd0, 24'h00_0000, 24'hFF_FFFF);
        draw_pixel(1'b1);
        draw_pixel(1'b0);
        draw_pixel(1'b0);

        set_column(32'h0000_0000, 32'h0000_4000, 11'd1, 24'h00_FF00, 24'hFF_00FF);
        draw_pixel(1'b1);
        draw_pixel(1'b0);
        draw_pixel(1'b0);

        set_column(BOTTOM_EDGE, 32'hFFFF_C000, 11'd1024, 24'($urandom), 24'($urandom));
        draw_pixel(1'b1);
        draw_pixel(1'b0);
        draw_pixel(1'b0);

        send_item(MODE_LOAD, 1'b1, 10'h3FF, 24'hFF_FFFF);
        send_item(MODE_LOAD, 1'b0, 10'h000, 24'h00_0000);
        set_column(32'h0000_0000, 32'h0000_0000, 11'd1024, 24'hFF_FFFF, 24'hFF_FFFF);
        draw_pixel(1'b1);

        // Random columns, with heavier idling on the receive side, then on the send side, then none.
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 37 : (p == 1) ? 82 : 0;
            recv_idle_pct = (p == 0) ? 82 : (p == 1) ? 37 : 0;
            phase_count = 0;
            if (p == 2) begin
                hold_requests++;  // long output hold-off while items keep coming
                random_column(40, phase_count);
            end
            while (phase_count < PHASE_ITEMS) begin
                random_column($urandom_range(4, 40), phase_count);
            end
        end

        drain();
        $display("Covered %0d items with %0d pixels checked over %0d column settings,",
                 items_sent, checked, columns);
        $display("swapping idle sides and holding the output off for %0d cycles once.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
